// ===== rtl/mta_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mta_pkg;

  localparam int VERTEX_DEPTH_DEF = 4096;
  localparam int FRAC_BITS_DEF    = 16;
  localparam int IDX_W            = 12;
  localparam int Q_W              = 32;
  localparam int CNT_W            = 8;
  // covers 2^(2*24) for the reciprocal and the weighted sum of the average
  localparam int DIV_W            = 50;

  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_TRI   = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_CLEAR = 2'd3;

  typedef struct packed {
    logic [1:0]            func;
    logic [IDX_W-1:0]      index_a;
    logic [IDX_W-1:0]      index_b;
    logic [IDX_W-1:0]      index_c;
    logic signed [Q_W-1:0] pos_x;
    logic signed [Q_W-1:0] pos_y;
    logic signed [Q_W-1:0] pos_z;
    logic signed [Q_W-1:0] tex_u;
    logic signed [Q_W-1:0] tex_v;
  } in_t;

  typedef struct packed {
    logic signed [Q_W-1:0] tangent_x;
    logic signed [Q_W-1:0] tangent_y;
    logic signed [Q_W-1:0] tangent_z;
    logic [CNT_W-1:0]      contributions;
    logic                  degenerate;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/mesh_tangent_accumulator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Per-vertex tangent accumulator.
// Input: an item (in_data) is taken when start is high and busy is low.
//   load writes one vertex (position, uv) and gives no result.
//   read returns a vertex's tangent and count via S_RDOUT and the output register.
//   triangle reads three vertices, builds the tangent through a shared
//   multiplier and a 1-bit-per-cycle divider (DIV_W steps per division),
//   then folds it into each corner; a degenerate one (zero uv determinant)
//   ends at S_DET with an all-zero result flagged degenerate.
//   An out-of-range index on read or triangle gives an all-zero result in the next cycle.
//   clear zeroes all counts by a sweep over all VERTEX_DEPTH entries.
// Output: out_valid strobes for one cycle with out_data; the receiver
//   cannot stall, so there is no back pressure.
// Reset: a sweep over all VERTEX_DEPTH entries clears the count memory; busy is
//   high until it ends. Position, uv and tangent memories are not cleared.
// Throughput is one item at a time, bound by the divider loop.
module mesh_tangent_accumulator #(
  parameter int VERTEX_DEPTH = mta_pkg::VERTEX_DEPTH_DEF,
  parameter int FRAC_BITS    = mta_pkg::FRAC_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 start,
  output logic                busy,
  input  wire  mta_pkg::in_t  in_data,
  output logic                out_valid,
  output mta_pkg::out_t       out_data
);

  localparam int AW   = $clog2(VERTEX_DEPTH);
  localparam int QW   = mta_pkg::Q_W;
  localparam int CW   = mta_pkg::CNT_W;
  localparam int DW   = mta_pkg::DIV_W;
  localparam int VW   = 5 * QW;
  localparam int TW   = 3 * QW;
  localparam int AC_W = QW + CW + 2;

  typedef enum logic [15:0] {
    S_IDLE  = 16'b0000_0000_0000_0001,
    S_CLR   = 16'b0000_0000_0000_0010,
    S_TA    = 16'b0000_0000_0000_0100,
    S_TB    = 16'b0000_0000_0000_1000,
    S_TC    = 16'b0000_0000_0001_0000,
    S_MUL   = 16'b0000_0000_0010_0000,
    S_DET   = 16'b0000_0000_0100_0000,
    S_RCP   = 16'b0000_0000_1000_0000,
    S_MUL_T = 16'b0000_0001_0000_0000,
    S_F_RD  = 16'b0000_0010_0000_0000,
    S_F_CAP = 16'b0000_0100_0000_0000,
    S_F_ACC = 16'b0000_1000_0000_0000,
    S_F_GO  = 16'b0001_0000_0000_0000,
    S_F_DIV = 16'b0010_0000_0000_0000,
    S_F_WR  = 16'b0100_0000_0000_0000,
    S_RDOUT = 16'b1000_0000_0000_0000
  } state_t;

  function automatic logic signed [QW-1:0] sat32(input logic signed [63:0] x);
    logic signed [QW-1:0] r;
    if (x > 64'sd2147483647) begin
      r = {1'b0, {(QW-1){1'b1}}};
    end else if (x < -64'sd2147483648) begin
      r = {1'b1, {(QW-1){1'b0}}};
    end else begin
      r = QW'(x);
    end
    return r;
  endfunction

  function automatic logic signed [QW-1:0] fsub(input logic signed [QW-1:0] a,
                                                input logic signed [QW-1:0] b);
    logic signed [QW:0] d;
    logic signed [QW-1:0] r;
    d = (QW+1)'(a) - (QW+1)'(b);
    if (d[QW] != d[QW-1]) begin
      r = d[QW] ? {1'b1, {(QW-1){1'b0}}} : {1'b0, {(QW-1){1'b1}}};
    end else begin
      r = QW'(d);
    end
    return r;
  endfunction

  function automatic logic in_range(input logic [mta_pkg::IDX_W-1:0] idx);
    return 32'(idx) < VERTEX_DEPTH;
  endfunction

  state_t state_r, state_nxt;

  logic [AW-1:0] ia_r, ia_nxt, ib_r, ib_nxt, ic_r, ic_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [3:0]    mstep_r, mstep_nxt;
  logic [1:0]    corner_r, corner_nxt;
  logic [1:0]    k_r, k_nxt;
  logic          neg_r, neg_nxt;
  logic [CW-1:0] n_r, n_nxt;

  logic signed [QW-1:0] apos_r [3], apos_nxt [3];
  logic signed [QW-1:0] auv_r  [2], auv_nxt  [2];
  logic signed [QW-1:0] e1_r [3], e1_nxt [3];
  logic signed [QW-1:0] e2_r [3], e2_nxt [3];
  logic signed [QW-1:0] du1x_r, du1x_nxt, du1y_r, du1y_nxt;
  logic signed [QW-1:0] du2x_r, du2x_nxt, du2y_r, du2y_nxt;
  logic signed [QW-1:0] prod_r [11], prod_nxt [11];
  logic signed [QW-1:0] num_r [3], num_nxt [3];
  logic signed [QW-1:0] recip_r, recip_nxt;
  logic signed [QW-1:0] tan_r [3], tan_nxt [3];
  logic signed [QW-1:0] newt_r [3], newt_nxt [3];
  logic signed [AC_W-1:0] acc_r, acc_nxt;

  logic          out_valid_r, out_valid_nxt;
  mta_pkg::out_t out_data_r, out_data_nxt;

  // memories
  logic          vtx_we;
  logic [AW-1:0] vtx_raddr;
  logic [VW-1:0] vtx_wdata, vtx_rdata;
  logic          tan_we;
  logic [AW-1:0] tan_raddr, tan_waddr;
  logic [TW-1:0] tan_wdata, tan_rdata;
  logic          cnt_we;
  logic [AW-1:0] cnt_waddr;
  logic [CW-1:0] cnt_wdata, cnt_rdata;

  // shared units
  logic signed [QW-1:0] ma, mb, fm;
  logic signed [63:0]   mp;
  logic                 div_start, div_done;
  logic [DW-1:0]        div_dividend, div_quot;
  logic [QW-1:0]        div_divisor;
  logic signed [63:0]   qs;
  logic signed [QW-1:0] det;
  logic [DW-1:0]        one2;
  logic                 accept;
  logic [AW-1:0]        corner_addr;
  logic signed [QW-1:0] vb [5];

  assign accept    = start && !busy;
  assign busy      = state_r != S_IDLE;
  assign one2      = DW'(1) << (2 * FRAC_BITS);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  mta_ram #(.WIDTH(VW), .DEPTH(VERTEX_DEPTH)) u_vtx_ram (
    .clk(clk), .we(vtx_we), .waddr(AW'(in_data.index_a)), .wdata(vtx_wdata),
    .raddr(vtx_raddr), .rdata(vtx_rdata)
  );

  mta_ram #(.WIDTH(TW), .DEPTH(VERTEX_DEPTH)) u_tan_ram (
    .clk(clk), .we(tan_we), .waddr(tan_waddr), .wdata(tan_wdata),
    .raddr(tan_raddr), .rdata(tan_rdata)
  );

  mta_ram #(.WIDTH(CW), .DEPTH(VERTEX_DEPTH)) u_cnt_ram (
    .clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
    .raddr(tan_raddr), .rdata(cnt_rdata)
  );

  mta_div #(.W(DW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_dividend),
    .divisor(div_divisor), .done(div_done), .quotient(div_quot)
  );

  assign vtx_wdata = {in_data.tex_v, in_data.tex_u, in_data.pos_z,
                      in_data.pos_y, in_data.pos_x};
  assign vtx_we    = accept && in_data.func == mta_pkg::FUNC_LOAD &&
                     in_range(in_data.index_a);

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      vb[i] = vtx_rdata[i*QW +: QW];
    end
  end

  always_comb begin
    case (corner_r)
      2'd0:    corner_addr = ia_r;
      2'd1:    corner_addr = ib_r;
      default: corner_addr = ic_r;
    endcase
  end

  always_comb begin
    case (state_r)
      S_TA:    vtx_raddr = ib_r;
      S_TB:    vtx_raddr = ic_r;
      default: vtx_raddr = AW'(in_data.index_a);
    endcase
    tan_raddr = (state_r == S_F_RD) ? corner_addr : AW'(in_data.index_a);
  end

  // multiplier operand select, one product per cycle in S_MUL and S_MUL_T
  always_comb begin
    case (mstep_r)
      4'd0:    begin ma = du1x_r;  mb = du2y_r;   end
      4'd1:    begin ma = du1y_r;  mb = du2x_r;   end
      4'd2:    begin ma = du2y_r;  mb = e1_r[0];  end
      4'd3:    begin ma = du1y_r;  mb = e2_r[0];  end
      4'd4:    begin ma = du2y_r;  mb = e1_r[1];  end
      4'd5:    begin ma = du1y_r;  mb = e2_r[1];  end
      4'd6:    begin ma = du2y_r;  mb = e1_r[2];  end
      4'd7:    begin ma = du1y_r;  mb = e2_r[2];  end
      4'd8:    begin ma = recip_r; mb = num_r[0]; end
      4'd9:    begin ma = recip_r; mb = num_r[1]; end
      default: begin ma = recip_r; mb = num_r[2]; end
    endcase
    mp = 64'(ma) * 64'(mb);
    fm = sat32(mp >>> FRAC_BITS);
  end

  assign det = fsub(prod_r[0], prod_r[1]);
  assign qs  = neg_r ? -$signed(64'(div_quot)) : $signed(64'(div_quot));

  always_comb begin
    if (state_r == S_F_GO) begin
      div_dividend = DW'(acc_r[AC_W-1] ? -acc_r : acc_r);
      div_divisor  = QW'(n_r) + 1'b1;
    end else begin
      div_dividend = one2;
      div_divisor  = det[QW-1] ? ~det + 1'b1 : det;
    end
    div_start = (state_r == S_DET && det != '0) || state_r == S_F_GO;
  end

  always_comb begin
    state_nxt     = state_r;
    ia_nxt        = ia_r;
    ib_nxt        = ib_r;
    ic_nxt        = ic_r;
    clr_nxt       = clr_r;
    mstep_nxt     = mstep_r;
    corner_nxt    = corner_r;
    k_nxt         = k_r;
    neg_nxt       = neg_r;
    n_nxt         = n_r;
    apos_nxt      = apos_r;
    auv_nxt       = auv_r;
    e1_nxt        = e1_r;
    e2_nxt        = e2_r;
    du1x_nxt      = du1x_r;
    du1y_nxt      = du1y_r;
    du2x_nxt      = du2x_r;
    du2y_nxt      = du2y_r;
    prod_nxt      = prod_r;
    num_nxt       = num_r;
    recip_nxt     = recip_r;
    tan_nxt       = tan_r;
    newt_nxt      = newt_r;
    acc_nxt       = acc_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = out_data_r;
    tan_we        = 1'b0;
    tan_waddr     = corner_addr;
    tan_wdata     = {newt_r[2], newt_r[1], newt_r[0]};
    cnt_we        = 1'b0;
    cnt_waddr     = corner_addr;
    cnt_wdata     = (n_r == '1) ? n_r : n_r + 1'b1;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ia_nxt = AW'(in_data.index_a);
          ib_nxt = AW'(in_data.index_b);
          ic_nxt = AW'(in_data.index_c);
          case (in_data.func)
            mta_pkg::FUNC_TRI: begin
              if (in_range(in_data.index_a) && in_range(in_data.index_b) &&
                  in_range(in_data.index_c)) begin
                state_nxt = S_TA;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
              end
            end
            mta_pkg::FUNC_READ: begin
              if (in_range(in_data.index_a)) begin
                state_nxt = S_RDOUT;
              end else begin
                out_valid_nxt = 1'b1;
                out_data_nxt  = '0;
              end
            end
            mta_pkg::FUNC_CLEAR: begin
              clr_nxt   = '0;
              state_nxt = S_CLR;
            end
            default: ;
          endcase
        end
      end
      S_CLR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        cnt_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(VERTEX_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_RDOUT: begin
        out_valid_nxt = 1'b1;
        out_data_nxt  = {tan_rdata[QW-1:0], tan_rdata[2*QW-1:QW],
                         tan_rdata[3*QW-1:2*QW], cnt_rdata, 1'b0};
        state_nxt     = S_IDLE;
      end
      S_TA: begin
        for (int i = 0; i < 3; i++) apos_nxt[i] = vb[i];
        auv_nxt[0] = vb[3];
        auv_nxt[1] = vb[4];
        state_nxt  = S_TB;
      end
      S_TB: begin
        for (int i = 0; i < 3; i++) e1_nxt[i] = fsub(vb[i], apos_r[i]);
        du1x_nxt  = fsub(vb[3], auv_r[0]);
        du1y_nxt  = fsub(vb[4], auv_r[1]);
        state_nxt = S_TC;
      end
      S_TC: begin
        for (int i = 0; i < 3; i++) e2_nxt[i] = fsub(vb[i], apos_r[i]);
        du2x_nxt  = fsub(vb[3], auv_r[0]);
        du2y_nxt  = fsub(vb[4], auv_r[1]);
        mstep_nxt = '0;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt[mstep_r] = fm;
        mstep_nxt         = mstep_r + 1'b1;
        if (mstep_r == 4'd7) begin
          state_nxt = S_DET;
        end
      end
      S_DET: begin
        for (int i = 0; i < 3; i++) num_nxt[i] = fsub(prod_r[2+2*i], prod_r[3+2*i]);
        neg_nxt = det[QW-1];
        if (det == '0) begin
          // zero uv determinant: skip the triangle
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.degenerate = 1'b1;
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_RCP;
        end
      end
      S_RCP: begin
        if (div_done) begin
          recip_nxt = sat32(qs);
          state_nxt = S_MUL_T;
        end
      end
      S_MUL_T: begin
        prod_nxt[mstep_r] = fm;
        mstep_nxt         = mstep_r + 1'b1;
        if (mstep_r == 4'd10) begin
          corner_nxt = '0;
          state_nxt  = S_F_RD;
        end
      end
      S_F_RD: begin
        state_nxt = S_F_CAP;
      end
      S_F_CAP: begin
        for (int i = 0; i < 3; i++) tan_nxt[i] = tan_rdata[i*QW +: QW];
        n_nxt     = cnt_rdata;
        k_nxt     = '0;
        state_nxt = S_F_ACC;
      end
      S_F_ACC: begin
        if (n_r == '0) begin
          newt_nxt[k_r] = prod_r[8+k_r];
          k_nxt         = k_r + 1'b1;
          state_nxt     = (k_r == 2'd2) ? S_F_WR : S_F_ACC;
        end else begin
          acc_nxt   = AC_W'(tan_r[k_r]) * AC_W'($signed({1'b0, n_r})) +
                      AC_W'(prod_r[8+k_r]);
          state_nxt = S_F_GO;
        end
      end
      S_F_GO: begin
        neg_nxt   = acc_r[AC_W-1];
        state_nxt = S_F_DIV;
      end
      S_F_DIV: begin
        if (div_done) begin
          newt_nxt[k_r] = sat32(qs);
          k_nxt         = k_r + 1'b1;
          state_nxt     = (k_r == 2'd2) ? S_F_WR : S_F_ACC;
        end
      end
      S_F_WR: begin
        tan_we     = 1'b1;
        cnt_we     = 1'b1;
        corner_nxt = corner_r + 1'b1;
        if (corner_r == 2'd2) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {prod_r[8], prod_r[9], prod_r[10], {CW{1'b0}}, 1'b0};
          state_nxt     = S_IDLE;
        end else begin
          state_nxt = S_F_RD;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ia_r       <= ia_nxt;
    ib_r       <= ib_nxt;
    ic_r       <= ic_nxt;
    mstep_r    <= mstep_nxt;
    corner_r   <= corner_nxt;
    k_r        <= k_nxt;
    neg_r      <= neg_nxt;
    n_r        <= n_nxt;
    apos_r     <= apos_nxt;
    auv_r      <= auv_nxt;
    e1_r       <= e1_nxt;
    e2_r       <= e2_nxt;
    du1x_r     <= du1x_nxt;
    du1y_r     <= du1y_nxt;
    du2x_r     <= du2x_nxt;
    du2y_r     <= du2y_nxt;
    prod_r     <= prod_nxt;
    num_r      <= num_nxt;
    recip_r    <= recip_nxt;
    tan_r      <= tan_nxt;
    newt_r     <= newt_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef SYNTHESIS
  a_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> state_r == S_IDLE)
    else $error("result strobe outside idle");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_RCP || state_r == S_F_DIV))
    else $error("divider finished with nobody waiting");

  a_degen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.tangent_x == '0 && out_data.tangent_y == '0 &&
      out_data.tangent_z == '0 && out_data.contributions == '0)
    else $error("degenerate triangle carries a tangent");

  a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_data.func == mta_pkg::FUNC_CLEAR |=> busy && state_r == S_CLR)
    else $error("clear transaction did not start the sweep");
`endif

endmodule

`default_nettype wire

// ===== rtl/mta_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mta_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire  [$clog2(DEPTH)-1:0] waddr,
  input  wire  [WIDTH-1:0]         wdata,
  input  wire  [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/mta_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mta_div #(
  parameter int W = mta_pkg::DIV_W
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  input  wire  [W-1:0]              dividend,
  input  wire  [mta_pkg::Q_W-1:0]   divisor,
  output logic                      done,
  output logic [W-1:0]              quotient
);

  localparam int CW = $clog2(W + 1);

  logic [mta_pkg::Q_W-1:0] rem_r, rem_nxt;
  logic [W-1:0]            quo_r, quo_nxt;
  logic [mta_pkg::Q_W-1:0] dvs_r, dvs_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic                    run_r, run_nxt;
  logic                    done_r, done_nxt;
  logic [mta_pkg::Q_W:0]   trial;
  logic                    fits;

  // restoring division, one quotient bit per cycle
  always_comb begin
    trial    = {rem_r, quo_r[W-1]};
    fits     = trial >= {1'b0, dvs_r};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dvs_nxt  = dvs_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      dvs_nxt = divisor;
      cnt_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      rem_nxt = fits ? mta_pkg::Q_W'(trial - {1'b0, dvs_r}) : mta_pkg::Q_W'(trial);
      quo_nxt = {quo_r[W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

`default_nettype wire

// ===== test/mesh_tangent_accumulator_tb.sv =====
`timescale 1ns / 1ps

module mesh_tangent_accumulator_tb;

  localparam int DEPTH = mta_pkg::VERTEX_DEPTH_DEF;
  localparam int FRAC = mta_pkg::FRAC_BITS_DEF;
  localparam longint Q_MAX = 64'sd2147483647;
  localparam longint Q_MIN = -64'sd2147483648;
  localparam int ONE = 32'h0001_0000;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DRAIN_CYCLES = 700;
  localparam int RANDOM_ITEMS = 600;

  typedef struct {
    mta_pkg::in_t  item;
    bit            typed;
    mta_pkg::out_t want;
  } row_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  mta_pkg::in_t  in_data;
  logic          out_valid;
  mta_pkg::out_t out_data;

  // shadow of the vertex, tangent and count stores
  int       pos_mem[DEPTH][3];
  int       uv_mem[DEPTH][2];
  int       tan_mem[DEPTH][3];
  bit [7:0] cnt_mem[DEPTH];
  bit       loaded[DEPTH];
  bit       tan_ok[DEPTH];
  int       loaded_list[$];
  int       tan_list[$];

  mta_pkg::out_t pending_results[$];
  row_t          directed[$];
  int            errors = 0;
  int            cycles = 0;
  int            idle_pct;

  mesh_tangent_accumulator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int q_sat(longint x);
    if (x > Q_MAX) return int'(Q_MAX);
    if (x < Q_MIN) return int'(Q_MIN);
    return int'(x);
  endfunction

  function automatic int q_mul(int a, int b);
    longint p;
    p = longint'(a) * longint'(b);
    return q_sat(p >>> FRAC);
  endfunction

  function automatic int q_sub(int a, int b);
    return q_sat(longint'(a) - longint'(b));
  endfunction

  function automatic void fold_tangent(int v, int t[3]);
    longint n;
    longint acc;
    n = cnt_mem[v];
    for (int k = 0; k < 3; k++) begin
      if (n == 0) begin
        tan_mem[v][k] = t[k];
      end else begin
        acc = longint'(tan_mem[v][k]) * n + longint'(t[k]);
        tan_mem[v][k] = q_sat(acc / (n + 1));
      end
    end
    if (cnt_mem[v] != 8'd255) cnt_mem[v] = cnt_mem[v] + 8'd1;
    if (!tan_ok[v]) begin
      tan_ok[v] = 1'b1;
      tan_list.push_back(v);
    end
  endfunction

  // updates the shadow stores; returns 1 when the transaction yields a result
  function automatic bit predict_tangent(mta_pkg::in_t it, output mta_pkg::out_t res);
    int a, b, c;
    int du1x, du1y, du2x, du2y, det, recip, num;
    int e1[3];
    int e2[3];
    int t[3];
    a = it.index_a;
    b = it.index_b;
    c = it.index_c;
    res = '0;
    case (it.func)
      mta_pkg::FUNC_LOAD: begin
        pos_mem[a][0] = it.pos_x;
        pos_mem[a][1] = it.pos_y;
        pos_mem[a][2] = it.pos_z;
        uv_mem[a][0] = it.tex_u;
        uv_mem[a][1] = it.tex_v;
        if (!loaded[a]) begin
          loaded[a] = 1'b1;
          loaded_list.push_back(a);
        end
        return 1'b0;
      end
      mta_pkg::FUNC_CLEAR: begin
        foreach (cnt_mem[i]) cnt_mem[i] = 8'd0;
        return 1'b0;
      end
      mta_pkg::FUNC_READ: begin
        res.tangent_x = tan_mem[a][0];
        res.tangent_y = tan_mem[a][1];
        res.tangent_z = tan_mem[a][2];
        res.contributions = cnt_mem[a];
        return 1'b1;
      end
      default: begin
        du1x = q_sub(uv_mem[b][0], uv_mem[a][0]);
        du1y = q_sub(uv_mem[b][1], uv_mem[a][1]);
        du2x = q_sub(uv_mem[c][0], uv_mem[a][0]);
        du2y = q_sub(uv_mem[c][1], uv_mem[a][1]);
        det = q_sub(q_mul(du1x, du2y), q_mul(du1y, du2x));
        for (int k = 0; k < 3; k++) begin
          e1[k] = q_sub(pos_mem[b][k], pos_mem[a][k]);
          e2[k] = q_sub(pos_mem[c][k], pos_mem[a][k]);
        end
        if (det == 0) begin
          res.degenerate = 1'b1;
        end else begin
          recip = q_sat((64'sd1 << (2 * FRAC)) / longint'(det));
          for (int k = 0; k < 3; k++) begin
            num = q_sub(q_mul(du2y, e1[k]), q_mul(du1y, e2[k]));
            t[k] = q_mul(recip, num);
          end
          res.tangent_x = t[0];
          res.tangent_y = t[1];
          res.tangent_z = t[2];
          fold_tangent(a, t);
          fold_tangent(b, t);
          fold_tangent(c, t);
        end
        return 1'b1;
      end
    endcase
  endfunction

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("mesh_tangent_accumulator_tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    mta_pkg::out_t want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report("result with no transaction waiting");
      end else begin
        want = pending_results.pop_front();
        if (out_data.tangent_x !== want.tangent_x)
          report($sformatf("tangent_x %h want %h", out_data.tangent_x, want.tangent_x));
        if (out_data.tangent_y !== want.tangent_y)
          report($sformatf("tangent_y %h want %h", out_data.tangent_y, want.tangent_y));
        if (out_data.tangent_z !== want.tangent_z)
          report($sformatf("tangent_z %h want %h", out_data.tangent_z, want.tangent_z));
        if (out_data.contributions !== want.contributions)
          report($sformatf("contributions %0d want %0d",
                           out_data.contributions, want.contributions));
        if (out_data.degenerate !== want.degenerate)
          report($sformatf("degenerate %b want %b", out_data.degenerate, want.degenerate));
      end
    end
  end

  task automatic send(mta_pkg::in_t it, bit typed, mta_pkg::out_t want);
    mta_pkg::out_t res;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (busy);
    if (predict_tangent(it, res)) pending_results.push_back(typed ? want : res);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic mta_pkg::in_t make_item(bit [1:0] f, int a, int b, int c,
                                             int x, int y, int z, int u, int v);
    mta_pkg::in_t it;
    it.func = f;
    it.index_a = a[mta_pkg::IDX_W-1:0];
    it.index_b = b[mta_pkg::IDX_W-1:0];
    it.index_c = c[mta_pkg::IDX_W-1:0];
    it.pos_x = x;
    it.pos_y = y;
    it.pos_z = z;
    it.tex_u = u;
    it.tex_v = v;
    return it;
  endfunction

  function automatic void add_row(mta_pkg::in_t it, bit typed, mta_pkg::out_t want);
    row_t r;
    r.item = it;
    r.typed = typed;
    r.want = want;
    directed.push_back(r);
  endfunction

  function automatic int rand_q();
    case ($urandom_range(4))
      0: return $urandom;
      1: return $urandom_range(1) ? int'(Q_MAX) : int'(Q_MIN);
      default: return int'($urandom_range(32'h0008_0000)) - 32'h0004_0000;
    endcase
  endfunction

  // coarse uv grid so that some random triangles come out degenerate
  function automatic int rand_uv();
    case ($urandom_range(5))
      0: return $urandom;
      1: return 0;
      2: return ONE;
      3: return ONE / 2;
      default: return int'($urandom_range(32'h0004_0000)) - 32'h0002_0000;
    endcase
  endfunction

  function automatic int pick_loaded();
    return loaded_list[$urandom_range(loaded_list.size() - 1)];
  endfunction

  function automatic mta_pkg::in_t random_item();
    int sel;
    int a, b, c;
    sel = $urandom_range(99);
    if (sel < 2) return make_item(mta_pkg::FUNC_CLEAR, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom, $urandom, $urandom);
    if (sel < 27 || loaded_list.size() < 3) begin
      a = (loaded_list.size() > 0 && $urandom_range(3) == 0) ? pick_loaded()
                                                            : $urandom_range(DEPTH - 1);
      return make_item(mta_pkg::FUNC_LOAD, a, $urandom, $urandom,
                       rand_q(), rand_q(), rand_q(), rand_uv(), rand_uv());
    end
    if (sel < 52 && tan_list.size() > 0) begin
      a = tan_list[$urandom_range(tan_list.size() - 1)];
      return make_item(mta_pkg::FUNC_READ, a, $urandom, $urandom,
                       $urandom, $urandom, $urandom, $urandom, $urandom);
    end
    a = pick_loaded();
    b = pick_loaded();
    c = ($urandom_range(15) == 0) ? a : pick_loaded();
    return make_item(mta_pkg::FUNC_TRI, a, b, c,
                     $urandom, $urandom, $urandom, $urandom, $urandom);
  endfunction

  initial begin
    mta_pkg::out_t none;
    mta_pkg::out_t degen;
    mta_pkg::in_t  it;
    none = '0;
    degen = '0;
    degen.degenerate = 1'b1;
    idle_pct = 35;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;

    add_row(make_item(mta_pkg::FUNC_LOAD, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_LOAD, 1, 0, 0, ONE, 0, 0, ONE, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_LOAD, 2, 0, 0, 0, ONE, 0, 0, ONE), 0, none);
    add_row(make_item(mta_pkg::FUNC_TRI, 0, 1, 2, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_READ, 1, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_LOAD, 4095, 4095, 4095, int'(Q_MAX), int'(Q_MAX),
                      int'(Q_MAX), ONE, ONE), 0, none);
    add_row(make_item(mta_pkg::FUNC_LOAD, 2048, 0, 0, int'(Q_MIN), int'(Q_MIN), int'(Q_MIN),
                      0, ONE), 0, none);
    add_row(make_item(mta_pkg::FUNC_TRI, 4095, 2048, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_READ, 4095, 0, 0, 0, 0, 0, 0, 0), 0, none);
    // repeated corners, or corners that share a uv, always leave a zero uv determinant
    add_row(make_item(mta_pkg::FUNC_TRI, 0, 0, 0, 0, 0, 0, 0, 0), 1, degen);
    add_row(make_item(mta_pkg::FUNC_TRI, 1, 2, 2, 0, 0, 0, 0, 0), 1, degen);
    add_row(make_item(mta_pkg::FUNC_LOAD, 3, 0, 0, -1, -1, -1, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_TRI, 0, 3, 1, 0, 0, 0, 0, 0), 1, degen);
    add_row(make_item(mta_pkg::FUNC_CLEAR, 4095, 4095, 4095, -1, -1, -1, -1, -1), 0, none);
    add_row(make_item(mta_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_TRI, 0, 1, 2, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_READ, 0, 0, 0, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_LOAD, 4095, 0, 0, int'(Q_MAX), int'(Q_MIN), 0,
                      int'(Q_MAX), int'(Q_MIN)), 0, none);
    add_row(make_item(mta_pkg::FUNC_TRI, 4095, 1, 2, 0, 0, 0, 0, 0), 0, none);
    add_row(make_item(mta_pkg::FUNC_READ, 4095, 0, 0, 0, 0, 0, 0, 0), 0, none);

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i]) send(directed[i].item, directed[i].typed, directed[i].want);
    drain();

    // one triangle folded often enough to pin the counts at their ceiling
    send(make_item(mta_pkg::FUNC_LOAD, 10, 0, 0, 32'h0003_0000, 32'h0001_0000,
                   -32'h0002_0000, ONE, 0), 0, none);
    send(make_item(mta_pkg::FUNC_LOAD, 11, 0, 0, 32'h0000_8000, -32'h0004_0000,
                   32'h0001_0000, 0, ONE), 0, none);
    send(make_item(mta_pkg::FUNC_LOAD, 12, 0, 0, -32'h0001_0000, 32'h0002_0000,
                   32'h0005_0000, ONE * 2, ONE), 0, none);
    for (int i = 0; i < 262; i++) begin
      send(make_item(mta_pkg::FUNC_TRI, 10, 11, 12, 0, 0, 0, 0, 0), 0, none);
      if (i % 50 == 0 || i > 252) send(make_item(mta_pkg::FUNC_READ, 10 + i % 3, 0, 0,
                                                 0, 0, 0, 0, 0), 0, none);
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) idle_pct = 62;
      if (i == 2 * RANDOM_ITEMS / 3) idle_pct = 0;
      if (i == RANDOM_ITEMS / 2) drain();
      it = random_item();
      send(it, 0, none);
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("mesh_tangent_accumulator_tb: clean");
    end else begin
      $display("mesh_tangent_accumulator_tb: errors");
    end
    $finish;
  end

endmodule
